[rtl/core/wbps_pkg.sv]
// Shared types, constants and compare functions for the wildcard byte pattern search.
`default_nettype none

package wbps_pkg;

    // Longest pattern and depth of the sliding byte window.
    localparam int MAX_PATTERN  = 16;
    localparam int WINDOW_DEPTH = MAX_PATTERN;
    // Width of the running byte count and of the stored first-hit offset.
    localparam int OFFSET_BITS  = 32;
    // Widths fixed by the interface.
    localparam int LEN_W        = 5;
    localparam int OUT_OFF_W    = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int LEN_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = LEN_W'(1);
    localparam logic [7:0]       WILDCARD_RST       = 8'd17;

    typedef logic [7:0]                     t_byte;
    typedef logic [WINDOW_DEPTH-1:0][7:0]   t_window;
    typedef logic [MAX_PATTERN-1:0][7:0]    t_pattern;
    typedef logic [OFFSET_BITS-1:0]         t_offset;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_WILDCARD_VALUE = 2'd3
    } t_cfg_idx;

    // Clamp the programmed length into the range 1 to MAX_PATTERN.
    function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_PATTERN)) begin
            res = LEN_W'(MAX_PATTERN);
        end
        return res;
    endfunction

    // Match result for every pattern length at once. Bit L-1 is set when the
    // newest L window bytes match the first L pattern bytes; pattern byte j
    // lines up with window byte L-1-j.
    function automatic logic [MAX_PATTERN-1:0] match_by_length(
        input t_window  win,
        input t_pattern pat,
        input t_byte    wild
    );
        logic [MAX_PATTERN-1:0] hits;
        logic                   ok;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            ok = 1'b1;
            for (int j = 0; j < l; j++) begin
                if ((pat[j] != wild) && (pat[j] != win[l-1-j])) begin
                    ok = 1'b0;
                end
            end
            hits[l-1] = ok;
        end
        return hits;
    endfunction

    // Report an offset on the 32-bit result field, saturating if it is wider.
    function automatic logic [OUT_OFF_W-1:0] clamp_offset(input t_offset v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[OUT_OFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/wildcard_byte_pattern_search.sv]
// Top level of the wildcard byte pattern search: window, compare and result register.
// The last byte of a region passes the input register, then sets o_out_valid in the result register.
// Throughput: one byte per cycle; the compare for all lengths is one stage, and bytes keep
// flowing while a result waits, until a second last byte meets that waiting result.
// Reset (i_rst_n low, synchronous) empties both stages, clears the byte count and the kept
// hit, and restores the configuration defaults: pattern zero, length 1, wildcard 17.
`default_nettype none

module wildcard_byte_pattern_search (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Byte stream input
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_last_byte,
    // Result output
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_found,
    output logic [wbps_pkg::OUT_OFF_W-1:0]           o_match_offset,
    // Configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [63:0]                      r_pattern_low;
    logic [63:0]                      r_pattern_high;
    logic [wbps_pkg::LEN_W-1:0]       r_pattern_length;
    wbps_pkg::t_byte                  r_wildcard;

    // Input stage.
    logic                             r_in_valid;
    wbps_pkg::t_byte                  r_in_data;
    logic                             r_in_last;

    // Stream state.
    wbps_pkg::t_window                r_window;
    wbps_pkg::t_offset                r_bytes_seen;
    logic                             r_hit_seen;
    wbps_pkg::t_offset                r_hit_offset;

    // Result stage.
    logic                             r_out_valid;
    logic                             r_out_found;
    logic [wbps_pkg::OUT_OFF_W-1:0]   r_out_offset;

    // Next values and compare logic.
    logic                             in_take;
    logic                             proc;
    wbps_pkg::t_window                n_window;
    wbps_pkg::t_offset                n_bytes_seen;
    logic                             n_hit_seen;
    wbps_pkg::t_offset                n_hit_offset;
    logic [wbps_pkg::LEN_W-1:0]       len_used;
    logic [wbps_pkg::LEN_IDX_W-1:0]   len_idx;
    wbps_pkg::t_pattern               pattern;
    logic [wbps_pkg::MAX_PATTERN-1:0] len_hits;
    logic                             hit_now;

    // The configuration port takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= wbps_pkg::PATTERN_LENGTH_RST;
            r_wildcard       <= wbps_pkg::WILDCARD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (wbps_pkg::t_cfg_idx'(i_cfg_index))
                wbps_pkg::CFG_PATTERN_LOW: begin
                    r_pattern_low <= i_cfg_data;
                end
                wbps_pkg::CFG_PATTERN_HIGH: begin
                    r_pattern_high <= i_cfg_data;
                end
                wbps_pkg::CFG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                end
                wbps_pkg::CFG_WILDCARD_VALUE: begin
                    r_wildcard <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The held byte moves on unless it is a last byte and the result slot is
    // still occupied by a result that is not taken this cycle.
    assign proc       = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Window shift, saturating byte count and parallel compare.
    always_comb begin
        n_window = {r_window[wbps_pkg::WINDOW_DEPTH-2:0], r_in_data};
        if (r_bytes_seen == '1) begin
            n_bytes_seen = r_bytes_seen;
        end else begin
            n_bytes_seen = r_bytes_seen + wbps_pkg::OFFSET_BITS'(1);
        end
        len_used = wbps_pkg::used_length(r_pattern_length);
        len_idx  = wbps_pkg::LEN_IDX_W'(len_used - wbps_pkg::LEN_W'(1));
        pattern  = (wbps_pkg::MAX_PATTERN * 8)'({r_pattern_high, r_pattern_low});
        len_hits = wbps_pkg::match_by_length(n_window, pattern, r_wildcard);
        hit_now  = !r_hit_seen
                 && (n_bytes_seen >= wbps_pkg::OFFSET_BITS'(len_used))
                 && len_hits[len_idx];
        n_hit_seen   = r_hit_seen || hit_now;
        n_hit_offset = hit_now ? (n_bytes_seen - wbps_pkg::OFFSET_BITS'(len_used))
                               : r_hit_offset;
    end

    // Stream state: the last byte of a region returns it to the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_hit_seen   <= 1'b0;
            r_hit_offset <= '0;
        end else if (proc) begin
            if (r_in_last) begin
                r_bytes_seen <= '0;
                r_hit_seen   <= 1'b0;
                r_hit_offset <= '0;
            end else begin
                r_bytes_seen <= n_bytes_seen;
                r_hit_seen   <= n_hit_seen;
                r_hit_offset <= n_hit_offset;
            end
        end
    end

    // Window bytes are read only after the count shows they were written.
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_window <= n_window;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out_found  <= n_hit_seen;
            r_out_offset <= n_hit_seen ? wbps_pkg::clamp_offset(n_hit_offset) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_match_offset = r_out_offset;

    // A result with no match always reports offset zero.
    a_no_hit_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_offset == '0))
        else $error("result without a match carries a nonzero offset");

    // A kept hit always lies wholly inside the bytes counted so far.
    a_hit_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_seen |-> ((33'(r_hit_offset) + 33'(len_used)) <= 33'(r_bytes_seen)))
        else $error("first hit offset lies beyond the counted bytes");

    // A new result appears only after a last byte was processed.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_in_valid && r_in_last))
        else $error("result appeared without a last byte");

    // The input side stalls only while the input register holds a last byte and a stalled result waits.
    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked last byte");

endmodule

`default_nettype wire
